>>> src/fcb_pkg.sv
// ----------------------------------------------------------------------------
// fcb_pkg
// shared widths, constants, register codes and beat types for the cluster
// bounds pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package fcb_pkg;

    // limits of the tiling
    localparam int MAX_TILES  = 64;
    localparam int MAX_SLICES = 64;

    // field widths
    localparam int TILE_W  = 7;
    localparam int FOV_W   = 20;
    localparam int DEPTH_W = 32;
    localparam int COORD_W = 6;
    localparam int CELL_W  = 18;
    localparam int OUT_W   = 32;
    localparam int CFG_IDX_W = 2;

    // fixed point
    localparam int FRAC_W     = 16;
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);

    // half extents
    localparam int HH_PROD_W = DEPTH_W + FOV_W;
    localparam int HH_W      = HH_PROD_W - FRAC_W;
    localparam int HW_PROD_W = HH_W + FOV_W;
    localparam int HW_W      = HW_PROD_W - FRAC_W;

    // edges and edge products
    localparam int EDGE_W = 9;
    localparam int PROD_W = 49;
    localparam int ROWTX_W = COORD_W + TILE_W;
    localparam int TXTY_W  = 2 * TILE_W;
    localparam int CELL_SUM_W = COORD_W + TXTY_W;
    localparam int SLICE_CMP_W = 9;

    // padding: ((near + far) * 5 + 50000) / 100000, done as >> 5 then / 3125
    localparam int PAD_X_W         = 36;
    localparam int PAD_MUL         = 5;
    localparam int PAD_BIAS        = 50000;
    localparam int PAD_SHIFT       = 5;
    localparam int PAD_Y_W         = PAD_X_W - PAD_SHIFT;
    localparam int PAD_DIV         = 3125;
    localparam logic [31:0] PAD_RECIP = 32'd2814749767;
    localparam int PAD_RECIP_SHIFT = 43;
    localparam int PAD_P_W         = PAD_Y_W + 32;
    localparam int PAD_W           = 19;
    localparam int PAD_R_W         = 32;

    // long division lanes
    localparam int LANES      = 4;
    localparam int LANE_XLO   = 0;
    localparam int LANE_XHI   = 1;
    localparam int LANE_YLO   = 2;
    localparam int LANE_YHI   = 3;
    localparam int DIV_W      = PROD_W - 1;
    localparam int REM_W      = TILE_W;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIV_W / DIV_STEP;

    // output arithmetic
    localparam int SUM_W = 50;

    localparam int FRONT_STAGES = 5;
    localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + 1;

    // register reset values
    localparam logic [TILE_W-1:0] TILES_X_RST = 7'd16;
    localparam logic [TILE_W-1:0] TILES_Y_RST = 7'd9;
    localparam logic [FOV_W-1:0]  TAN_RST     = 20'd65536;
    localparam logic [FOV_W-1:0]  ASPECT_RST  = 20'd116508;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILES_X = 2'd0,
        CFG_TILES_Y = 2'd1,
        CFG_TAN     = 2'd2,
        CFG_ASPECT  = 2'd3
    } cfg_idx_t;

    // effective setup seen by the datapath
    typedef struct packed {
        logic [TILE_W-1:0] tiles_x;
        logic [TILE_W-1:0] tiles_y;
        logic [FOV_W-1:0]  tan_half_fov;
        logic [FOV_W-1:0]  aspect;
    } cfg_t;

    // values that ride alongside the divider lanes
    typedef struct packed {
        logic [PAD_W-1:0]   pad;
        logic [DEPTH_W-1:0] dmin;
        logic [DEPTH_W-1:0] dmax;
        logic [CELL_W-1:0]  cell_idx;
        logic [LANES-1:0]   neg;
    } side_t;

    typedef struct packed {
        logic [LANES-1:0][DIV_W-1:0] num;
        side_t                       side;
    } work_t;

    // zero acts as one, counts above the limit act as the limit
    function automatic logic [TILE_W-1:0] eff_count(input logic [TILE_W-1:0] v);
        logic [TILE_W-1:0] r;
        if (v == '0)
            r = TILE_W'(1);
        else if (v > TILE_W'(MAX_TILES))
            r = TILE_W'(MAX_TILES);
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/fcb_front.sv
// ----------------------------------------------------------------------------
// fcb_front
// five stage front end: half extents, padding, edge products, min/max and
// signed-magnitude dividends for the divider lanes
// ----------------------------------------------------------------------------
`default_nettype none

module fcb_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire fcb_pkg::cfg_t                    cfg,
    input  wire logic                             in_valid,
    input  wire logic [fcb_pkg::COORD_W-1:0]      tile_col,
    input  wire logic [fcb_pkg::COORD_W-1:0]      tile_row,
    input  wire logic [fcb_pkg::COORD_W-1:0]      slice_num,
    input  wire logic [fcb_pkg::DEPTH_W-1:0]      near_depth,
    input  wire logic [fcb_pkg::DEPTH_W-1:0]      far_depth,
    output logic                                  out_valid,
    output fcb_pkg::work_t                        out_data
);

    // signed edge times unsigned extent, both widened first
    function automatic logic signed [fcb_pkg::PROD_W-1:0] mul_edge(
        input logic signed [fcb_pkg::EDGE_W-1:0] e,
        input logic [fcb_pkg::HW_W-1:0]          h
    );
        logic signed [fcb_pkg::PROD_W-1:0] ew;
        logic signed [fcb_pkg::PROD_W-1:0] hw;
        ew = {{(fcb_pkg::PROD_W - fcb_pkg::EDGE_W){e[fcb_pkg::EDGE_W-1]}}, e};
        hw = $signed({{(fcb_pkg::PROD_W - fcb_pkg::HW_W){1'b0}}, h});
        return fcb_pkg::PROD_W'(ew * hw);
    endfunction

    function automatic logic signed [fcb_pkg::PROD_W-1:0] min2(
        input logic signed [fcb_pkg::PROD_W-1:0] a,
        input logic signed [fcb_pkg::PROD_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [fcb_pkg::PROD_W-1:0] max2(
        input logic signed [fcb_pkg::PROD_W-1:0] a,
        input logic signed [fcb_pkg::PROD_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    // ---------------- stage 1 ----------------
    logic                                 s1_valid_reg;
    logic [fcb_pkg::HH_W-1:0]             s1_hh0_reg, s1_hh0_next;
    logic [fcb_pkg::HH_W-1:0]             s1_hh1_reg, s1_hh1_next;
    logic signed [fcb_pkg::EDGE_W-1:0]    s1_ex0_reg, s1_ex0_next;
    logic signed [fcb_pkg::EDGE_W-1:0]    s1_ex1_reg, s1_ex1_next;
    logic signed [fcb_pkg::EDGE_W-1:0]    s1_ey0_reg, s1_ey0_next;
    logic signed [fcb_pkg::EDGE_W-1:0]    s1_ey1_reg, s1_ey1_next;
    logic [fcb_pkg::DEPTH_W-1:0]          s1_dmin_reg, s1_dmin_next;
    logic [fcb_pkg::DEPTH_W-1:0]          s1_dmax_reg, s1_dmax_next;
    logic [fcb_pkg::PAD_Y_W-1:0]          s1_pady_reg, s1_pady_next;
    logic [fcb_pkg::COORD_W-1:0]          s1_col_reg;
    logic [fcb_pkg::COORD_W-1:0]          s1_slice_reg, s1_slice_next;
    logic [fcb_pkg::ROWTX_W-1:0]          s1_rowtx_reg, s1_rowtx_next;
    logic [fcb_pkg::TXTY_W-1:0]           s1_txty_reg, s1_txty_next;

    logic [fcb_pkg::HH_PROD_W-1:0]        hh_prod0;
    logic [fcb_pkg::HH_PROD_W-1:0]        hh_prod1;
    logic [fcb_pkg::PAD_X_W-1:0]          pad_x;

    always_comb
    begin
        hh_prod0 = fcb_pkg::HH_PROD_W'(near_depth) * fcb_pkg::HH_PROD_W'(cfg.tan_half_fov);
        hh_prod1 = fcb_pkg::HH_PROD_W'(far_depth) * fcb_pkg::HH_PROD_W'(cfg.tan_half_fov);
        s1_hh0_next = fcb_pkg::HH_W'((hh_prod0 + fcb_pkg::HH_PROD_W'(fcb_pkg::ROUND_HALF))
                                     >> fcb_pkg::FRAC_W);
        s1_hh1_next = fcb_pkg::HH_W'((hh_prod1 + fcb_pkg::HH_PROD_W'(fcb_pkg::ROUND_HALF))
                                     >> fcb_pkg::FRAC_W);

        // normalized edges scaled by the tile count: 2k - T
        s1_ex0_next = $signed(fcb_pkg::EDGE_W'({tile_col, 1'b0})
                              - fcb_pkg::EDGE_W'(cfg.tiles_x));
        s1_ex1_next = $signed(fcb_pkg::EDGE_W'({tile_col, 1'b0}) + fcb_pkg::EDGE_W'(2)
                              - fcb_pkg::EDGE_W'(cfg.tiles_x));
        s1_ey0_next = $signed(fcb_pkg::EDGE_W'({tile_row, 1'b0})
                              - fcb_pkg::EDGE_W'(cfg.tiles_y));
        s1_ey1_next = $signed(fcb_pkg::EDGE_W'({tile_row, 1'b0}) + fcb_pkg::EDGE_W'(2)
                              - fcb_pkg::EDGE_W'(cfg.tiles_y));

        s1_dmin_next = (near_depth < far_depth) ? near_depth : far_depth;
        s1_dmax_next = (near_depth < far_depth) ? far_depth : near_depth;

        pad_x = (fcb_pkg::PAD_X_W'(near_depth) + fcb_pkg::PAD_X_W'(far_depth))
                * fcb_pkg::PAD_X_W'(fcb_pkg::PAD_MUL) + fcb_pkg::PAD_X_W'(fcb_pkg::PAD_BIAS);
        s1_pady_next = pad_x[fcb_pkg::PAD_X_W-1:fcb_pkg::PAD_SHIFT];

        if ({{(fcb_pkg::SLICE_CMP_W - fcb_pkg::COORD_W){1'b0}}, slice_num}
            >= fcb_pkg::SLICE_CMP_W'(fcb_pkg::MAX_SLICES))
            s1_slice_next = fcb_pkg::COORD_W'(fcb_pkg::MAX_SLICES - 1);
        else
            s1_slice_next = slice_num;

        s1_rowtx_next = fcb_pkg::ROWTX_W'(tile_row) * fcb_pkg::ROWTX_W'(cfg.tiles_x);
        s1_txty_next  = fcb_pkg::TXTY_W'(cfg.tiles_x) * fcb_pkg::TXTY_W'(cfg.tiles_y);
    end

    // ---------------- stage 2 ----------------
    logic                                 s2_valid_reg;
    logic [fcb_pkg::HW_W-1:0]             s2_hw0_reg, s2_hw0_next;
    logic [fcb_pkg::HW_W-1:0]             s2_hw1_reg, s2_hw1_next;
    logic [fcb_pkg::HH_W-1:0]             s2_hh0_reg, s2_hh1_reg;
    logic signed [fcb_pkg::EDGE_W-1:0]    s2_ex0_reg, s2_ex1_reg, s2_ey0_reg, s2_ey1_reg;
    logic [fcb_pkg::DEPTH_W-1:0]          s2_dmin_reg, s2_dmax_reg;
    logic [fcb_pkg::PAD_Y_W-1:0]          s2_pady_reg;
    logic [fcb_pkg::PAD_W-1:0]            s2_q0_reg, s2_q0_next;
    logic [fcb_pkg::CELL_W-1:0]           s2_cell_reg, s2_cell_next;

    logic [fcb_pkg::HW_PROD_W-1:0]        hw_prod0;
    logic [fcb_pkg::HW_PROD_W-1:0]        hw_prod1;
    logic [fcb_pkg::PAD_P_W-1:0]          pad_prod;
    logic [fcb_pkg::CELL_SUM_W-1:0]       cell_sum;

    always_comb
    begin
        hw_prod0 = fcb_pkg::HW_PROD_W'(s1_hh0_reg) * fcb_pkg::HW_PROD_W'(cfg.aspect);
        hw_prod1 = fcb_pkg::HW_PROD_W'(s1_hh1_reg) * fcb_pkg::HW_PROD_W'(cfg.aspect);
        s2_hw0_next = fcb_pkg::HW_W'((hw_prod0 + fcb_pkg::HW_PROD_W'(fcb_pkg::ROUND_HALF))
                                     >> fcb_pkg::FRAC_W);
        s2_hw1_next = fcb_pkg::HW_W'((hw_prod1 + fcb_pkg::HW_PROD_W'(fcb_pkg::ROUND_HALF))
                                     >> fcb_pkg::FRAC_W);

        // reciprocal estimate, at most one below the true quotient
        pad_prod = fcb_pkg::PAD_P_W'(s1_pady_reg) * fcb_pkg::PAD_P_W'(fcb_pkg::PAD_RECIP);
        s2_q0_next = fcb_pkg::PAD_W'(pad_prod >> fcb_pkg::PAD_RECIP_SHIFT);

        cell_sum = fcb_pkg::CELL_SUM_W'(s1_col_reg) + fcb_pkg::CELL_SUM_W'(s1_rowtx_reg)
                   + fcb_pkg::CELL_SUM_W'(s1_slice_reg) * fcb_pkg::CELL_SUM_W'(s1_txty_reg);
        s2_cell_next = cell_sum[fcb_pkg::CELL_W-1:0];
    end

    // ---------------- stage 3 ----------------
    logic                                 s3_valid_reg;
    logic signed [fcb_pkg::PROD_W-1:0]    s3_prod_reg [8];
    logic signed [fcb_pkg::PROD_W-1:0]    s3_prod_next [8];
    logic [fcb_pkg::PAD_W-1:0]            s3_pad_reg, s3_pad_next;
    logic [fcb_pkg::DEPTH_W-1:0]          s3_dmin_reg, s3_dmax_reg;
    logic [fcb_pkg::CELL_W-1:0]           s3_cell_reg;

    logic [fcb_pkg::PAD_R_W-1:0]          pad_rem;
    logic [fcb_pkg::HW_W-1:0]             hh0_w;
    logic [fcb_pkg::HW_W-1:0]             hh1_w;

    always_comb
    begin
        hh0_w = fcb_pkg::HW_W'(s2_hh0_reg);
        hh1_w = fcb_pkg::HW_W'(s2_hh1_reg);
        // x uses half widths, y uses half heights
        s3_prod_next[0] = mul_edge(s2_ex0_reg, s2_hw0_reg);
        s3_prod_next[1] = mul_edge(s2_ex1_reg, s2_hw0_reg);
        s3_prod_next[2] = mul_edge(s2_ex0_reg, s2_hw1_reg);
        s3_prod_next[3] = mul_edge(s2_ex1_reg, s2_hw1_reg);
        s3_prod_next[4] = mul_edge(s2_ey0_reg, hh0_w);
        s3_prod_next[5] = mul_edge(s2_ey1_reg, hh0_w);
        s3_prod_next[6] = mul_edge(s2_ey0_reg, hh1_w);
        s3_prod_next[7] = mul_edge(s2_ey1_reg, hh1_w);

        pad_rem = fcb_pkg::PAD_R_W'(s2_pady_reg)
                  - fcb_pkg::PAD_R_W'(s2_q0_reg) * fcb_pkg::PAD_R_W'(fcb_pkg::PAD_DIV);
        if (pad_rem >= fcb_pkg::PAD_R_W'(fcb_pkg::PAD_DIV))
            s3_pad_next = s2_q0_reg + fcb_pkg::PAD_W'(1);
        else
            s3_pad_next = s2_q0_reg;
    end

    // ---------------- stage 4 ----------------
    logic                                 s4_valid_reg;
    logic signed [fcb_pkg::PROD_W-1:0]    s4_ext_reg [fcb_pkg::LANES];
    logic signed [fcb_pkg::PROD_W-1:0]    s4_ext_next [fcb_pkg::LANES];
    logic [fcb_pkg::PAD_W-1:0]            s4_pad_reg;
    logic [fcb_pkg::DEPTH_W-1:0]          s4_dmin_reg, s4_dmax_reg;
    logic [fcb_pkg::CELL_W-1:0]           s4_cell_reg;

    // rounding divide is monotonic, so extremes can be picked before it
    always_comb
    begin
        s4_ext_next[fcb_pkg::LANE_XLO] = min2(min2(s3_prod_reg[0], s3_prod_reg[1]),
                                              min2(s3_prod_reg[2], s3_prod_reg[3]));
        s4_ext_next[fcb_pkg::LANE_XHI] = max2(max2(s3_prod_reg[0], s3_prod_reg[1]),
                                              max2(s3_prod_reg[2], s3_prod_reg[3]));
        s4_ext_next[fcb_pkg::LANE_YLO] = min2(min2(s3_prod_reg[4], s3_prod_reg[5]),
                                              min2(s3_prod_reg[6], s3_prod_reg[7]));
        s4_ext_next[fcb_pkg::LANE_YHI] = max2(max2(s3_prod_reg[4], s3_prod_reg[5]),
                                              max2(s3_prod_reg[6], s3_prod_reg[7]));
    end

    // ---------------- stage 5 ----------------
    logic                                 s5_valid_reg;
    fcb_pkg::work_t                       s5_data_reg, s5_data_next;

    always_comb
    begin
        logic signed [fcb_pkg::PROD_W-1:0] mag;
        logic [fcb_pkg::TILE_W-1:0]        t;
        for (int l = 0; l < fcb_pkg::LANES; l++)
        begin
            t = (l < fcb_pkg::LANE_YLO) ? cfg.tiles_x : cfg.tiles_y;
            s5_data_next.side.neg[l] = s4_ext_reg[l][fcb_pkg::PROD_W-1];
            mag = s4_ext_reg[l][fcb_pkg::PROD_W-1] ? -s4_ext_reg[l] : s4_ext_reg[l];
            // magnitude plus half the count gives round half away from zero
            s5_data_next.num[l] = fcb_pkg::DIV_W'(mag) + fcb_pkg::DIV_W'(t >> 1);
        end
        s5_data_next.side.pad      = s4_pad_reg;
        s5_data_next.side.dmin     = s4_dmin_reg;
        s5_data_next.side.dmax     = s4_dmax_reg;
        s5_data_next.side.cell_idx = s4_cell_reg;
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        s1_hh0_reg   <= s1_hh0_next;
        s1_hh1_reg   <= s1_hh1_next;
        s1_ex0_reg   <= s1_ex0_next;
        s1_ex1_reg   <= s1_ex1_next;
        s1_ey0_reg   <= s1_ey0_next;
        s1_ey1_reg   <= s1_ey1_next;
        s1_dmin_reg  <= s1_dmin_next;
        s1_dmax_reg  <= s1_dmax_next;
        s1_pady_reg  <= s1_pady_next;
        s1_col_reg   <= tile_col;
        s1_slice_reg <= s1_slice_next;
        s1_rowtx_reg <= s1_rowtx_next;
        s1_txty_reg  <= s1_txty_next;

        s2_hw0_reg  <= s2_hw0_next;
        s2_hw1_reg  <= s2_hw1_next;
        s2_hh0_reg  <= s1_hh0_reg;
        s2_hh1_reg  <= s1_hh1_reg;
        s2_ex0_reg  <= s1_ex0_reg;
        s2_ex1_reg  <= s1_ex1_reg;
        s2_ey0_reg  <= s1_ey0_reg;
        s2_ey1_reg  <= s1_ey1_reg;
        s2_dmin_reg <= s1_dmin_reg;
        s2_dmax_reg <= s1_dmax_reg;
        s2_pady_reg <= s1_pady_reg;
        s2_q0_reg   <= s2_q0_next;
        s2_cell_reg <= s2_cell_next;

        for (int i = 0; i < 8; i++)
            s3_prod_reg[i] <= s3_prod_next[i];
        s3_pad_reg  <= s3_pad_next;
        s3_dmin_reg <= s2_dmin_reg;
        s3_dmax_reg <= s2_dmax_reg;
        s3_cell_reg <= s2_cell_reg;

        for (int l = 0; l < fcb_pkg::LANES; l++)
            s4_ext_reg[l] <= s4_ext_next[l];
        s4_pad_reg  <= s3_pad_reg;
        s4_dmin_reg <= s3_dmin_reg;
        s4_dmax_reg <= s3_dmax_reg;
        s4_cell_reg <= s3_cell_reg;

        s5_data_reg <= s5_data_next;
    end

    assign out_valid = s5_valid_reg;
    assign out_data  = s5_data_reg;

endmodule

`default_nettype wire

>>> src/fcb_divpipe.sv
// ----------------------------------------------------------------------------
// fcb_divpipe
// four-lane pipelined restoring divider, four quotient bits per stage,
// dividing each lane by its tile count
// ----------------------------------------------------------------------------
`default_nettype none

module fcb_divpipe (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fcb_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    input  wire fcb_pkg::work_t                in_data,
    output logic                               out_valid,
    output fcb_pkg::work_t                     out_data
);

    logic                        valid_reg [fcb_pkg::DIV_STAGES];
    logic [fcb_pkg::DIV_W-1:0]   num_reg   [fcb_pkg::DIV_STAGES][fcb_pkg::LANES];
    logic [fcb_pkg::DIV_W-1:0]   num_next  [fcb_pkg::DIV_STAGES][fcb_pkg::LANES];
    logic [fcb_pkg::REM_W-1:0]   rem_reg   [fcb_pkg::DIV_STAGES][fcb_pkg::LANES];
    logic [fcb_pkg::REM_W-1:0]   rem_next  [fcb_pkg::DIV_STAGES][fcb_pkg::LANES];
    fcb_pkg::side_t              side_reg  [fcb_pkg::DIV_STAGES];

    // the dividend shifts out at the top while quotient bits shift in below
    always_comb
    begin
        logic [fcb_pkg::DIV_W-1:0] n;
        logic [fcb_pkg::REM_W-1:0] r;
        logic [fcb_pkg::REM_W:0]   p;
        logic [fcb_pkg::REM_W:0]   t;
        logic                      qb;
        for (int s = 0; s < fcb_pkg::DIV_STAGES; s++)
        begin
            for (int l = 0; l < fcb_pkg::LANES; l++)
            begin
                t = (l < fcb_pkg::LANE_YLO) ? {1'b0, cfg.tiles_x} : {1'b0, cfg.tiles_y};
                if (s == 0)
                begin
                    n = in_data.num[l];
                    r = '0;
                end
                else
                begin
                    n = num_reg[s-1][l];
                    r = rem_reg[s-1][l];
                end
                for (int k = 0; k < fcb_pkg::DIV_STEP; k++)
                begin
                    p  = {r, n[fcb_pkg::DIV_W-1]};
                    qb = (p >= t);
                    r  = qb ? fcb_pkg::REM_W'(p - t) : fcb_pkg::REM_W'(p);
                    n  = {n[fcb_pkg::DIV_W-2:0], qb};
                end
                num_next[s][l] = n;
                rem_next[s][l] = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < fcb_pkg::DIV_STAGES; s++)
                valid_reg[s] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < fcb_pkg::DIV_STAGES; s++)
                valid_reg[s] <= valid_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_data.side;
        for (int s = 1; s < fcb_pkg::DIV_STAGES; s++)
            side_reg[s] <= side_reg[s-1];
        for (int s = 0; s < fcb_pkg::DIV_STAGES; s++)
            for (int l = 0; l < fcb_pkg::LANES; l++)
            begin
                num_reg[s][l] <= num_next[s][l];
                rem_reg[s][l] <= rem_next[s][l];
            end
    end

    always_comb
    begin
        for (int l = 0; l < fcb_pkg::LANES; l++)
            out_data.num[l] = num_reg[fcb_pkg::DIV_STAGES-1][l];
        out_data.side = side_reg[fcb_pkg::DIV_STAGES-1];
    end

    assign out_valid = valid_reg[fcb_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

>>> src/fcb_back.sv
// ----------------------------------------------------------------------------
// fcb_back
// restores quotient signs, applies padding, saturates and registers the
// result beat
// ----------------------------------------------------------------------------
`default_nettype none

module fcb_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire fcb_pkg::work_t                     in_data,
    output logic                                    result_valid,
    output logic signed [fcb_pkg::OUT_W-1:0]        box_min_x,
    output logic signed [fcb_pkg::OUT_W-1:0]        box_min_y,
    output logic signed [fcb_pkg::OUT_W-1:0]        box_min_z,
    output logic signed [fcb_pkg::OUT_W-1:0]        box_max_x,
    output logic signed [fcb_pkg::OUT_W-1:0]        box_max_y,
    output logic signed [fcb_pkg::OUT_W-1:0]        box_max_z,
    output logic [fcb_pkg::CELL_W-1:0]              cell_index
);

    function automatic logic signed [fcb_pkg::OUT_W-1:0] sat32(
        input logic signed [fcb_pkg::SUM_W-1:0] v
    );
        logic signed [fcb_pkg::SUM_W-1:0] hi_lim;
        logic signed [fcb_pkg::SUM_W-1:0] lo_lim;
        logic signed [fcb_pkg::OUT_W-1:0] r;
        hi_lim = {{(fcb_pkg::SUM_W - fcb_pkg::OUT_W + 1){1'b0}}, {(fcb_pkg::OUT_W-1){1'b1}}};
        lo_lim = {{(fcb_pkg::SUM_W - fcb_pkg::OUT_W + 1){1'b1}}, {(fcb_pkg::OUT_W-1){1'b0}}};
        if (v > hi_lim)
            r = hi_lim[fcb_pkg::OUT_W-1:0];
        else if (v < lo_lim)
            r = lo_lim[fcb_pkg::OUT_W-1:0];
        else
            r = v[fcb_pkg::OUT_W-1:0];
        return r;
    endfunction

    logic signed [fcb_pkg::SUM_W-1:0] coord [fcb_pkg::LANES];
    logic signed [fcb_pkg::SUM_W-1:0] pad_s;
    logic signed [fcb_pkg::SUM_W-1:0] dmin_s;
    logic signed [fcb_pkg::SUM_W-1:0] dmax_s;

    logic                              valid_reg;
    logic signed [fcb_pkg::OUT_W-1:0]  min_x_reg, min_x_next;
    logic signed [fcb_pkg::OUT_W-1:0]  min_y_reg, min_y_next;
    logic signed [fcb_pkg::OUT_W-1:0]  min_z_reg, min_z_next;
    logic signed [fcb_pkg::OUT_W-1:0]  max_x_reg, max_x_next;
    logic signed [fcb_pkg::OUT_W-1:0]  max_y_reg, max_y_next;
    logic signed [fcb_pkg::OUT_W-1:0]  max_z_reg, max_z_next;
    logic [fcb_pkg::CELL_W-1:0]        cell_reg;

    always_comb
    begin
        logic signed [fcb_pkg::SUM_W-1:0] q;
        for (int l = 0; l < fcb_pkg::LANES; l++)
        begin
            q = $signed({{(fcb_pkg::SUM_W - fcb_pkg::DIV_W){1'b0}}, in_data.num[l]});
            coord[l] = in_data.side.neg[l] ? -q : q;
        end
        pad_s  = $signed({{(fcb_pkg::SUM_W - fcb_pkg::PAD_W){1'b0}}, in_data.side.pad});
        dmin_s = $signed({{(fcb_pkg::SUM_W - fcb_pkg::DEPTH_W){1'b0}}, in_data.side.dmin});
        dmax_s = $signed({{(fcb_pkg::SUM_W - fcb_pkg::DEPTH_W){1'b0}}, in_data.side.dmax});

        min_x_next = sat32(coord[fcb_pkg::LANE_XLO] - pad_s);
        max_x_next = sat32(coord[fcb_pkg::LANE_XHI] + pad_s);
        min_y_next = sat32(coord[fcb_pkg::LANE_YLO] - pad_s);
        max_y_next = sat32(coord[fcb_pkg::LANE_YHI] + pad_s);
        // view space looks down minus z
        min_z_next = sat32(-dmax_s - pad_s);
        max_z_next = sat32(-dmin_s + pad_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        min_x_reg <= min_x_next;
        min_y_reg <= min_y_next;
        min_z_reg <= min_z_next;
        max_x_reg <= max_x_next;
        max_y_reg <= max_y_next;
        max_z_reg <= max_z_next;
        cell_reg  <= in_data.side.cell_idx;
    end

    assign result_valid = valid_reg;
    assign box_min_x    = min_x_reg;
    assign box_min_y    = min_y_reg;
    assign box_min_z    = min_z_reg;
    assign box_max_x    = max_x_reg;
    assign box_max_y    = max_y_reg;
    assign box_max_z    = max_z_reg;
    assign cell_index   = cell_reg;

endmodule

`default_nettype wire

>>> src/frustum_cluster_bounds.sv
// ----------------------------------------------------------------------------
// frustum_cluster_bounds
// padded view-space bounding box and linear index of one clustered-shading
// cell per beat
// ----------------------------------------------------------------------------
//
// usage
//   - command channel: a cell beat (tile_col, tile_row, slice_num, near_depth,
//     far_depth) is taken on a rising edge with start high and busy low
//   - busy is high only while reset is applied and for the first cycle after,
//     so a new cell can be issued on every clock
//   - result channel: result_valid pulses for one cycle with the box corners
//     and cell_index; the receiver has no way to hold results back
//   - the start beat reaches result_valid through five front stages (two
//     multiplier levels, edge products, min/max, dividends), twelve divider
//     stages of four quotient bits each and one output register
//   - throughput is one cell per cycle, set by the fully pipelined divider
//   - config channel: cfg_valid/cfg_ready with cfg_index selecting tiles_x,
//     tiles_y, tan_half_fov or the aspect register; write only while no cell
//     is in flight, since the pipeline reads the registers live
//   - reset flushes all stage valid bits and loads 16 x 9 tiles, tan 1.0 and
//     aspect about 16/9; cells in flight at reset are dropped
//
`default_nettype none

module frustum_cluster_bounds (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    // command channel
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [fcb_pkg::COORD_W-1:0]          tile_col,
    input  wire logic [fcb_pkg::COORD_W-1:0]          tile_row,
    input  wire logic [fcb_pkg::COORD_W-1:0]          slice_num,
    input  wire logic [fcb_pkg::DEPTH_W-1:0]          near_depth,
    input  wire logic [fcb_pkg::DEPTH_W-1:0]          far_depth,

    // config channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [fcb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [fcb_pkg::FOV_W-1:0]            cfg_data,

    // result channel
    output logic                                      result_valid,
    output logic signed [fcb_pkg::OUT_W-1:0]          box_min_x,
    output logic signed [fcb_pkg::OUT_W-1:0]          box_min_y,
    output logic signed [fcb_pkg::OUT_W-1:0]          box_min_z,
    output logic signed [fcb_pkg::OUT_W-1:0]          box_max_x,
    output logic signed [fcb_pkg::OUT_W-1:0]          box_max_y,
    output logic signed [fcb_pkg::OUT_W-1:0]          box_max_z,
    output logic [fcb_pkg::CELL_W-1:0]                cell_index
);

    // held high through reset so no beat lands in a flushing pipeline
    logic busy_reg;

    // configuration registers
    logic [fcb_pkg::TILE_W-1:0] tiles_x_reg;
    logic [fcb_pkg::TILE_W-1:0] tiles_y_reg;
    logic [fcb_pkg::FOV_W-1:0]  tan_reg;
    logic [fcb_pkg::FOV_W-1:0]  aspect_reg;

    fcb_pkg::cfg_t   cfg;
    logic            cmd_accept;
    logic            front_valid;
    fcb_pkg::work_t  front_data;
    logic            div_valid;
    fcb_pkg::work_t  div_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiles_x_reg <= fcb_pkg::TILES_X_RST;
            tiles_y_reg <= fcb_pkg::TILES_Y_RST;
            tan_reg     <= fcb_pkg::TAN_RST;
            aspect_reg  <= fcb_pkg::ASPECT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (fcb_pkg::cfg_idx_t'(cfg_index))
                fcb_pkg::CFG_TILES_X: tiles_x_reg <= cfg_data[fcb_pkg::TILE_W-1:0];
                fcb_pkg::CFG_TILES_Y: tiles_y_reg <= cfg_data[fcb_pkg::TILE_W-1:0];
                fcb_pkg::CFG_TAN:     tan_reg     <= cfg_data;
                fcb_pkg::CFG_ASPECT:  aspect_reg  <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign busy       = busy_reg;
    assign cfg_ready  = !busy_reg;
    assign cmd_accept = start && !busy_reg;

    // clamped tile counts feed the front end and the divider directly
    always_comb
    begin
        cfg.tiles_x      = fcb_pkg::eff_count(tiles_x_reg);
        cfg.tiles_y      = fcb_pkg::eff_count(tiles_y_reg);
        cfg.tan_half_fov = tan_reg;
        cfg.aspect       = aspect_reg;
    end

    // extents, padding, edge products and extremes
    fcb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (cmd_accept),
        .tile_col   (tile_col),
        .tile_row   (tile_row),
        .slice_num  (slice_num),
        .near_depth (near_depth),
        .far_depth  (far_depth),
        .out_valid  (front_valid),
        .out_data   (front_data)
    );

    // divide the four extremes by their tile counts
    fcb_divpipe u_divpipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    // signs, padding, saturation and the result register
    fcb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (div_valid),
        .in_data      (div_data),
        .result_valid (result_valid),
        .box_min_x    (box_min_x),
        .box_min_y    (box_min_y),
        .box_min_z    (box_min_z),
        .box_max_x    (box_max_x),
        .box_max_y    (box_max_y),
        .box_max_z    (box_max_z),
        .cell_index   (cell_index)
    );

    // every accepted cell comes out after the fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |-> ##(fcb_pkg::LATENCY) result_valid)
        else $error("accepted cell produced no result");

    // no result without a matching command beat
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(cmd_accept, fcb_pkg::LATENCY))
        else $error("result without a command beat");

    // box corners stay ordered on every axis
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (box_min_x <= box_max_x) && (box_min_y <= box_max_y))
        else $error("x or y bounds out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (box_min_z <= box_max_z))
        else $error("z bounds out of order");

endmodule

`default_nettype wire
